// ----- sv/tga_pkg.sv -----
// Shared types and constants for the TGA pixel stream decoder.
package tga_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_MODE        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd3;

   localparam logic [2:0] PIX_SIZE_2 = 3'd2;
   localparam logic [2:0] PIX_SIZE_3 = 3'd3;
   localparam logic [2:0] PIX_SIZE_4 = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic [2:0]  pixel_size;
      logic        rle_mode;
      logic [31:0] total;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

endpackage

// ----- sv/tga_csr.sv -----
// Configuration registers and the registered image pixel count.
module tga_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tga_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tga_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output tga_pkg::cfg_type                  cfg
);

   logic [2:0]  size_ff;
   logic        rle_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [31:0] total_ff;

   logic [2:0]  size_in;
   logic        rle_in;
   logic [15:0] width_in;
   logic [15:0] height_in;
   logic [31:0] product;
   logic [31:0] total_in;

   always_comb begin
      size_in   = size_ff;
      rle_in    = rle_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            tga_pkg::CSR_BYTES_PER_PIXEL: begin
               if (csr_wdata[2:0] == tga_pkg::PIX_SIZE_2 ||
                   csr_wdata[2:0] == tga_pkg::PIX_SIZE_4) begin
                  size_in = csr_wdata[2:0];
               end else begin
                  size_in = tga_pkg::PIX_SIZE_3;
               end
            end
            tga_pkg::CSR_RLE_MODE:     rle_in    = csr_wdata[0];
            tga_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            tga_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
      // The count follows the new sizes so an item taken at the same edge sees it.
      product  = 32'(width_in) * 32'(height_in);
      total_in = (product == 32'd0) ? 32'd1 : product;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= tga_pkg::PIX_SIZE_3;
         rle_ff    <= 1'b0;
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
         total_ff  <= 32'd1;
      end else begin
         size_ff   <= size_in;
         rle_ff    <= rle_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
      end
   end

   assign cfg.pixel_size = size_ff;
   assign cfg.rle_mode   = rle_ff;
   assign cfg.total      = total_ff;

endmodule

// ----- sv/tga_unpack.sv -----
// Unpacks a gathered pixel word into 8-bit red, green, blue and alpha.
module tga_unpack (
   input  logic [31:0]          full_word,
   input  logic [2:0]           pixel_size,
   output tga_pkg::pixel_type   pixel
);

   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;
   logic [7:0] b3;

   assign b0 = full_word[7:0];
   assign b1 = full_word[15:8];
   assign b2 = full_word[23:16];
   assign b3 = full_word[31:24];

   always_comb begin
      case (pixel_size)
         tga_pkg::PIX_SIZE_2: begin
            pixel.red   = {b1[6:2], 3'b000};
            pixel.green = {b1[1:0], b0[7:5], 3'b000};
            pixel.blue  = {b0[4:0], 3'b000};
            pixel.alpha = {b1[7], 7'b0000000};
         end
         tga_pkg::PIX_SIZE_4: begin
            pixel.red   = b2;
            pixel.green = b1;
            pixel.blue  = b0;
            pixel.alpha = b3;
         end
         default: begin
            pixel.red   = b2;
            pixel.green = b1;
            pixel.blue  = b0;
            pixel.alpha = tga_pkg::ALPHA_OPAQUE;
         end
      endcase
   end

endmodule

// ----- sv/tga_pixel_stream_decoder.sv -----
// Top level of the TGA pixel stream decoder: input register, decode step, result register.
//
// The block takes one pixel-data byte of a TGA image per clock and sustains that rate
// indefinitely while the result side keeps up. An accepted byte is held in an input
// register while the decode step runs on it; a byte that completes a pixel loads the
// result register as it leaves the input register, and the result is offered from
// there. Packet header bytes and bytes in the middle of a pixel give no result.
// A repeat packet gives a single item whose run_count carries the packet length, clipped
// to the pixels left in the image; the item that finishes the image has end_of_image set,
// and the block then rearms for the next image. The input accepts the next byte while a
// finished result still waits; it stalls only when a completing byte finds the result
// register full and held by rsp_stall. Configuration writes take effect for any byte
// accepted at the same edge or later; they never clear the decode state.
module tga_pixel_stream_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tga_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tga_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic [7:0]                        rsp_alpha,
   output logic [7:0]                        rsp_run_count,
   output logic                              rsp_end_of_image
);

   tga_pkg::cfg_type   cfg;
   tga_pkg::pixel_type pixel;

   tga_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Input register.
   logic       stage_valid_ff;
   logic       stage_valid_in;
   logic [7:0] stage_byte_ff;

   // Decode state.
   logic [23:0] buffer_ff;
   logic [23:0] buffer_in;
   logic [1:0]  index_ff;
   logic [1:0]  index_in;
   logic [7:0]  remaining_ff;
   logic [7:0]  remaining_in;
   logic        repeat_ff;
   logic        repeat_in;
   logic [31:0] done_ff;
   logic [31:0] done_in;

   // Result register.
   logic              out_valid_ff;
   logic              out_valid_in;
   tga_pkg::pixel_type out_pixel_ff;
   logic [7:0]        out_run_ff;
   logic              out_eoi_ff;

   logic        is_header;
   logic        is_partial;
   logic        has_result;
   logic        out_free;
   logic        fire;
   logic        req_take;
   logic [4:0]  shift_amt;
   logic [31:0] full_word;
   logic [31:0] left;
   logic        run_repeat;
   logic [7:0]  run;
   logic        end_image;

   assign is_header  = cfg.rle_mode && (remaining_ff == 8'd0);
   assign is_partial = ({1'b0, index_ff} + 3'd1) < cfg.pixel_size;
   assign has_result = !is_header && !is_partial;
   assign shift_amt  = {index_ff, 3'b000};
   assign full_word  = 32'(buffer_ff) | (32'(stage_byte_ff) << shift_amt);

   tga_unpack u_unpack (
      .full_word  (full_word),
      .pixel_size (cfg.pixel_size),
      .pixel      (pixel)
   );

   // The held item moves on unless it completes a pixel and the result register is held.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && (!has_result || out_free);
   assign req_stall = stage_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      left       = (cfg.total > done_ff) ? (cfg.total - done_ff) : 32'd1;
      run_repeat = cfg.rle_mode && repeat_ff;
      if (run_repeat) begin
         run = (left < 32'(remaining_ff)) ? left[7:0] : remaining_ff;
      end else begin
         run = 8'd1;
      end
      end_image = 32'(run) >= left;
   end

   always_comb begin
      buffer_in    = buffer_ff;
      index_in     = index_ff;
      remaining_in = remaining_ff;
      repeat_in    = repeat_ff;
      done_in      = done_ff;
      if (fire) begin
         if (is_header) begin
            repeat_in    = stage_byte_ff[7];
            remaining_in = 8'({1'b0, stage_byte_ff[6:0]}) + 8'd1;
         end else if (is_partial) begin
            buffer_in = buffer_ff | (24'(stage_byte_ff) << shift_amt);
            index_in  = index_ff + 2'd1;
         end else begin
            buffer_in = 24'd0;
            index_in  = 2'd0;
            if (run_repeat || !cfg.rle_mode) begin
               remaining_in = 8'd0;
            end else begin
               remaining_in = remaining_ff - 8'd1;
            end
            if (end_image) begin
               // Rearm for the next image.
               done_in      = 32'd0;
               remaining_in = 8'd0;
               repeat_in    = 1'b0;
            end else begin
               done_in = done_ff + 32'(run);
            end
         end
      end
   end

   always_comb begin
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
      if (fire && has_result) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         buffer_ff      <= 24'd0;
         index_ff       <= 2'd0;
         remaining_ff   <= 8'd0;
         repeat_ff      <= 1'b0;
         done_ff        <= 32'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         buffer_ff      <= buffer_in;
         index_ff       <= index_in;
         remaining_ff   <= remaining_in;
         repeat_ff      <= repeat_in;
         done_ff        <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff <= req_data_byte;
      end
      if (fire && has_result) begin
         out_pixel_ff <= pixel;
         out_run_ff   <= run;
         out_eoi_ff   <= end_image;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = out_pixel_ff.red;
   assign rsp_green        = out_pixel_ff.green;
   assign rsp_blue         = out_pixel_ff.blue;
   assign rsp_alpha        = out_pixel_ff.alpha;
   assign rsp_run_count    = out_run_ff;
   assign rsp_end_of_image = out_eoi_ff;

endmodule

// ----- sv/tga_checker.sv -----
// Port-level checker for the TGA pixel stream decoder and its bind.
module tga_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [7:0]                        rsp_red,
   input logic [7:0]                        rsp_green,
   input logic [7:0]                        rsp_blue,
   input logic [7:0]                        rsp_alpha,
   input logic [7:0]                        rsp_run_count,
   input logic                              rsp_end_of_image
);

   // A result held by the far side keeps its value and stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue,
         rsp_alpha, rsp_run_count, rsp_end_of_image}))
      else $error("held result changed");

   // Every run covers between one and one hundred twenty-eight pixels.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_count != 8'd0) && (rsp_run_count <= 8'd128))
      else $error("run count out of range");

   // The input only backs up behind a result that is itself held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind tga_pixel_stream_decoder tga_checker u_tga_checker (.*);
